// ===== design/pgd_pkg.sv =====
// ----------------------------------------------------------------------------
// Polar Gaussian deviate package
// Word types shared by the deviate core and its checker, and fixed constants of the core.
// ----------------------------------------------------------------------------
package pgd_pkg;

  typedef struct packed {
    logic [15:0]        uniform_a;
    logic [15:0]        uniform_b;
    logic signed [31:0] mean_value;
    logic [31:0]        spread;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] deviate;
    logic               rejected;
    logic               from_store;
  } out_word_t;

  localparam logic [31:0] TwoLn2Q30 = 32'd1488522236;
  localparam logic [22:0] DevMax    = 23'h7FFFFF;
  localparam int          RemW      = 86;

endpackage

// ===== design/polar_gaussian_deviate_core.sv =====
// ----------------------------------------------------------------------------
// Polar Gaussian deviate core
// Normal deviates by the polar method in fixed point, one word at a time.
// ----------------------------------------------------------------------------
// A word that finds a stored deviate goes through S_SCL and S_FIN to its result;
// a rejected pair goes through S_SQA, S_SQB, S_RCHK and S_FIN. A fresh pair is
// worked by the sequencer around one shared 32 x 32 multiplier and one shared 86-bit
// compare/subtract unit: 6 normalising steps, 24 squaring steps for the
// logarithm, two square roots of 32 steps each, and two divides
// of 25 steps each. in_stall_o is high from acceptance until the result is
// loaded into the output register, which then holds it until taken.
module polar_gaussian_deviate_core #(
  parameter int UNIFORM_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pgd_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pgd_pkg::out_word_t out_word_o
);

  localparam int          UB      = UNIFORM_BITS;
  localparam int          CoefOff = 2 * UB - 65;
  localparam logic [63:0] RLim    = 64'd1 << (2 * UB - 2);
  localparam logic [UB-1:0] Half  = UB'(1) << (UB - 1);
  localparam int          RemW_L  = pgd_pkg::RemW;

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001,
    S_SQA  = 17'h00002,
    S_SQB  = 17'h00004,
    S_RCHK = 17'h00008,
    S_NORM = 17'h00010,
    S_LOGM = 17'h00020,
    S_LOGU = 17'h00040,
    S_TMUL = 17'h00080,
    S_LCAP = 17'h00100,
    S_WSQ  = 17'h00200,
    S_SSQ  = 17'h00400,
    S_NMUL = 17'h00800,
    S_DLD  = 17'h01000,
    S_DSAT = 17'h02000,
    S_DIV  = 17'h04000,
    S_SCL  = 17'h08000,
    S_FIN  = 17'h10000
  } state_e;

  state_e state_q, state_d;
  logic   full_q, full_d;
  logic   out_valid_q, out_valid_d;

  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] maga_q, maga_d, magb_q, magb_d;
  logic        nega_q, nega_d, negb_q, negb_d;
  logic signed [31:0] mean_q, mean_d;
  logic [31:0] spread_q, spread_d;
  logic [63:0] norm_q, norm_d;
  logic [5:0]  lz_q, lz_d;
  logic [31:0] xs_q, xs_d;
  logic [23:0] f_q, f_d;
  logic [RemW_L-1:0] rem_q, rem_d, dsh_q, dsh_d;
  logic [63:0] rt_q, rt_d;
  logic [31:0] w_q, w_d, s_q, s_d;
  logic [23:0] quo_q, quo_d;
  logic        sat_q, sat_d, pass_q, pass_d;
  logic [23:0] zmag_q, zmag_d;
  logic        zneg_q, zneg_d;
  logic [23:0] stored_q, stored_d;
  logic        rej_q, rej_d, fromst_q, fromst_d;
  pgd_pkg::out_word_t out_q, out_d;

  logic        mul_en;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  pgd_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // shared compare/subtract unit
  logic              sq_mode;
  logic [RemW_L-1:0] cmp_y, cmp_diff;
  logic              cmp_ge;

  assign sq_mode  = (state_q == S_WSQ) || (state_q == S_SSQ);
  assign cmp_y    = sq_mode ? (RemW_L'(rt_q) + RemW_L'(dsh_q[63:0])) : dsh_q;
  assign cmp_ge   = rem_q >= cmp_y;
  assign cmp_diff = rem_q - cmp_y;

  always_comb begin
    logic [31:0]   ua32, ub32;
    logic [UB-1:0] ua, ub;
    logic [63:0]   rsum;
    logic [5:0]    k;
    logic [63:0]   nn;
    logic [5:0]    lzn;
    logic [32:0]   t33;
    logic [6:0]    coef;
    logic [30:0]   tval;
    logic [5:0]    e;
    logic [4:0]    h;
    logic [31:0]   m32;
    logic [63:0]   rt_n;
    logic [23:0]   quo_n;
    logic [22:0]   zq;
    logic [36:0]   qv;
    logic signed [39:0] sv, sum;

    state_d     = state_q;
    full_d      = full_q;
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    maga_d      = maga_q;
    magb_d      = magb_q;
    nega_d      = nega_q;
    negb_d      = negb_q;
    mean_d      = mean_q;
    spread_d    = spread_q;
    norm_d      = norm_q;
    lz_d        = lz_q;
    xs_d        = xs_q;
    f_d         = f_q;
    rem_d       = rem_q;
    dsh_d       = dsh_q;
    rt_d        = rt_q;
    w_d         = w_q;
    s_d         = s_q;
    quo_d       = quo_q;
    sat_d       = sat_q;
    pass_d      = pass_q;
    zmag_d      = zmag_q;
    zneg_d      = zneg_q;
    stored_d    = stored_q;
    rej_d       = rej_q;
    fromst_d    = fromst_q;
    out_d       = out_q;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;

    ua32  = {16'b0, in_word_i.uniform_a};
    ub32  = {16'b0, in_word_i.uniform_b};
    ua    = ua32[UB-1:0];
    ub    = ub32[UB-1:0];
    rsum  = norm_q + mul_p;
    k     = 6'd1 << cnt_q;
    nn    = norm_q;
    lzn   = lz_q;
    if ((norm_q >> (7'd64 - {1'b0, k})) == 64'd0) begin
      nn  = norm_q << k;
      lzn = lz_q + k;
    end
    t33   = mul_p[63:31];
    coef  = 7'(int'(lz_q) + CoefOff);
    tval  = {coef, 24'd0} - 31'(f_q);
    e     = ~lz_q;
    h     = e[5:1];
    m32   = e[0] ? norm_q[63:32] : {1'b0, norm_q[63:33]};
    rt_n  = cmp_ge ? ((rt_q >> 1) + dsh_q[63:0]) : (rt_q >> 1);
    quo_n = {quo_q[22:0], cmp_ge};
    zq    = (sat_q || quo_n[23]) ? pgd_pkg::DevMax : quo_n[22:0];
    qv    = mul_p[55:19];
    sv    = zneg_q ? -$signed(40'(qv)) : $signed(40'(qv));
    sum   = sv + 40'(mean_q);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mean_d   = in_word_i.mean_value;
          spread_d = in_word_i.spread;
          rej_d    = 1'b0;
          if (full_q) begin
            zneg_d   = stored_q[23];
            zmag_d   = stored_q[23] ? -stored_q : stored_q;
            full_d   = 1'b0;
            stored_d = '0;
            fromst_d = 1'b1;
            state_d  = S_SCL;
          end else begin
            nega_d   = ~ua[UB-1];
            negb_d   = ~ub[UB-1];
            maga_d   = 32'(ua[UB-1] ? (ua - Half) : (Half - ua));
            magb_d   = 32'(ub[UB-1] ? (ub - Half) : (Half - ub));
            fromst_d = 1'b0;
            pass_d   = 1'b0;
            state_d  = S_SQA;
          end
        end
      end
      S_SQA: begin
        mul_en  = 1'b1;
        mul_a   = maga_q;
        mul_b   = maga_q;
        state_d = S_SQB;
      end
      S_SQB: begin
        mul_en  = 1'b1;
        mul_a   = magb_q;
        mul_b   = magb_q;
        norm_d  = mul_p;
        state_d = S_RCHK;
      end
      S_RCHK: begin
        norm_d = rsum;
        lz_d   = '0;
        cnt_d  = 5'd5;
        if (rsum >= RLim || rsum == 64'd0) begin
          rej_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        norm_d = nn;
        lz_d   = lzn;
        cnt_d  = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          xs_d    = nn[63:32];
          f_d     = '0;
          cnt_d   = 5'd23;
          state_d = S_LOGM;
        end
      end
      S_LOGM: begin
        mul_en  = 1'b1;
        mul_a   = xs_q;
        mul_b   = xs_q;
        state_d = S_LOGU;
      end
      S_LOGU: begin
        xs_d  = t33[32] ? t33[32:1] : t33[31:0];
        f_d   = {f_q[22:0], t33[32]};
        cnt_d = cnt_q - 5'd1;
        state_d = (cnt_q == 5'd0) ? S_TMUL : S_LOGM;
      end
      S_TMUL: begin
        mul_en  = 1'b1;
        mul_a   = 32'(tval);
        mul_b   = pgd_pkg::TwoLn2Q30;
        state_d = S_LCAP;
      end
      S_LCAP: begin
        rem_d   = RemW_L'(mul_p[61:30]) << 24;
        rt_d    = '0;
        dsh_d   = RemW_L'(64'd1 << 62);
        cnt_d   = 5'd31;
        state_d = S_WSQ;
      end
      S_WSQ: begin
        if (cmp_ge) rem_d = cmp_diff;
        rt_d  = rt_n;
        dsh_d = dsh_q >> 2;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          w_d     = rt_n[31:0];
          rem_d   = RemW_L'(m32) << 30;
          rt_d    = '0;
          dsh_d   = RemW_L'(64'd1 << 62);
          cnt_d   = 5'd31;
          state_d = S_SSQ;
        end
      end
      S_SSQ: begin
        if (cmp_ge) rem_d = cmp_diff;
        rt_d  = rt_n;
        dsh_d = dsh_q >> 2;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          s_d     = (rt_n[31:0] == 32'd0) ? 32'd1 : rt_n[31:0];
          state_d = S_NMUL;
        end
      end
      S_NMUL: begin
        mul_en  = 1'b1;
        mul_a   = pass_q ? magb_q : maga_q;
        mul_b   = w_q;
        state_d = S_DLD;
      end
      S_DLD: begin
        rem_d   = RemW_L'(mul_p) << 25;
        dsh_d   = RemW_L'(s_q) << ({1'b0, h} + 6'd24);
        state_d = S_DSAT;
      end
      S_DSAT: begin
        sat_d   = cmp_ge;
        dsh_d   = dsh_q >> 1;
        quo_d   = '0;
        cnt_d   = 5'd23;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (cmp_ge) rem_d = cmp_diff;
        quo_d = quo_n;
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          if (!pass_q) begin
            stored_d = nega_q ? -{1'b0, zq} : {1'b0, zq};
            pass_d   = 1'b1;
            state_d  = S_NMUL;
          end else begin
            zmag_d  = {1'b0, zq};
            zneg_d  = negb_q;
            full_d  = 1'b1;
            state_d = S_SCL;
          end
        end
      end
      S_SCL: begin
        mul_en  = 1'b1;
        mul_a   = 32'(zmag_q);
        mul_b   = spread_q;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d        = 1'b1;
          out_d.rejected     = rej_q;
          out_d.from_store   = fromst_q;
          if (rej_q) begin
            out_d.deviate = '0;
          end else if (sum > 40'sd2147483647) begin
            out_d.deviate = 32'sh7FFFFFFF;
          end else if (sum < -40'sd2147483648) begin
            out_d.deviate = 32'sh80000000;
          end else begin
            out_d.deviate = sum[31:0];
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      pass_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      pass_q      <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    maga_q   <= maga_d;
    magb_q   <= magb_d;
    nega_q   <= nega_d;
    negb_q   <= negb_d;
    mean_q   <= mean_d;
    spread_q <= spread_d;
    norm_q   <= norm_d;
    lz_q     <= lz_d;
    xs_q     <= xs_d;
    f_q      <= f_d;
    rem_q    <= rem_d;
    dsh_q    <= dsh_d;
    rt_q     <= rt_d;
    w_q      <= w_d;
    s_q      <= s_d;
    quo_q    <= quo_d;
    sat_q    <= sat_d;
    zmag_q   <= zmag_d;
    zneg_q   <= zneg_d;
    stored_q <= stored_d;
    rej_q    <= rej_d;
    fromst_q <= fromst_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== design/pgd_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32 x 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module pgd_mul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= 64'(a_i) * 64'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

// ===== design/pgd_chk.sv =====
// ----------------------------------------------------------------------------
// Polar Gaussian deviate checker
// Port-level assertions on the deviate core, attached by bind.
// ----------------------------------------------------------------------------
module pgd_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input pgd_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input pgd_pkg::out_word_t out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.rejected && out_word_o.from_store))
    else $error("rejected word marked as stored");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.rejected |-> out_word_o.deviate == 32'sd0)
    else $error("rejected word carries a deviate");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("core ready straight after accepting a word");

endmodule

bind polar_gaussian_deviate_core pgd_chk u_pgd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polar Gaussian deviate core testbench
// Drives directed and random request words with random gaps and output
// stalls, predicts every deviate in fixed point and compares each result
// word field by field in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int UniBits = 16;
  localparam int IdleLimit = 3000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  pgd_pkg::in_word_t  in_word_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b1;
  pgd_pkg::out_word_t out_word_o;

  logic               store_full_q = 1'b0;
  logic [23:0]        stored_dev_q = '0;
  pgd_pkg::out_word_t deviate_q[$];
  int                 errors = 0;
  bit                 no_idle = 1'b0;
  int                 idle_cycles = 0;

  polar_gaussian_deviate_core #(.UNIFORM_BITS(UniBits)) dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint polar_leg(longint x, longint unsigned r2);
    int unsigned e, h;
    longint unsigned m, xs, f, t, l, w, mm, s, n, q;
    e = 0;
    f = 0;
    while (e < 63 && (r2 >> (e + 1)) != 0) e++;
    m = r2 << (62 - e);
    xs = m >> 31;
    for (int i = 0; i < 24; i++) begin
      xs = (xs * xs) >> 31;
      f <<= 1;
      if (xs >= (64'd1 << 32)) begin
        xs >>= 1;
        f |= 1;
      end
    end
    t = (longint'(2 * UniBits - 2 - e) << 24) - f;
    l = (t * longint'(pgd_pkg::TwoLn2Q30)) >> 30;
    w = int_sqrt(l << 24);
    if (e % 2 == 0) begin
      h = e / 2;
      mm = m >> 32;
    end else begin
      h = (e - 1) / 2;
      mm = m >> 31;
    end
    s = int_sqrt(mm << 30);
    if (s == 0) s = 1;
    n = longint'(x < 0 ? -x : x) * w;
    if (h >= 25) q = n / (s << (h - 25));
    else q = (n << (25 - h)) / s;
    if (q > longint'(pgd_pkg::DevMax)) q = longint'(pgd_pkg::DevMax);
    return x < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [31:0] scale_mean(longint z, logic [31:0] spread,
                                             logic signed [31:0] mean);
    longint unsigned mag, sp;
    longint q;
    mag = z < 0 ? -z : z;
    sp = {32'd0, spread};
    q = longint'((mag * sp) >> 19);
    if (z < 0) q = -q;
    q = q + longint'(mean);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic pgd_pkg::out_word_t polar_draw(pgd_pkg::in_word_t w);
    pgd_pkg::out_word_t r;
    longint a, b, z1, z2;
    longint unsigned r2;
    r = '0;
    if (store_full_q) begin
      r.deviate = scale_mean({{40{stored_dev_q[23]}}, stored_dev_q}, w.spread, w.mean_value);
      r.from_store = 1'b1;
      store_full_q = 1'b0;
      stored_dev_q = '0;
      return r;
    end
    a = longint'(w.uniform_a) - 32768;
    b = longint'(w.uniform_b) - 32768;
    r2 = a * a + b * b;
    if (r2 >= (64'd1 << (2 * UniBits - 2)) || r2 == 0) begin
      r.rejected = 1'b1;
      return r;
    end
    z1 = polar_leg(a, r2);
    z2 = polar_leg(b, r2);
    stored_dev_q = z1[23:0];
    store_full_q = 1'b1;
    r.deviate = scale_mean(z2, w.spread, w.mean_value);
    return r;
  endfunction

  // entered and left at a falling edge
  task automatic send_word(pgd_pkg::in_word_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_word_i = w;
    do @(posedge clk_i); while (in_stall_o);
    deviate_q = {deviate_q, polar_draw(w)};
    @(negedge clk_i);
  endtask

  function automatic pgd_pkg::in_word_t mk_word(int ua, int ub, int mean, int unsigned spread);
    pgd_pkg::in_word_t w;
    w.uniform_a = ua[15:0];
    w.uniform_b = ub[15:0];
    w.mean_value = mean;
    w.spread = spread;
    return w;
  endfunction

  function automatic pgd_pkg::in_word_t rand_word();
    pgd_pkg::in_word_t w;
    w.uniform_a = 16'($urandom);
    w.uniform_b = 16'($urandom);
    w.mean_value = ($urandom_range(0, 3) == 0) ? $urandom : $signed($urandom_range(0, 2 ** 22))
                   - 32'sd2097152;
    case ($urandom_range(0, 3))
      0: w.spread = $urandom;
      1: w.spread = $urandom_range(0, 32'h0004_0000);
      2: w.spread = 32'h0001_0000;
      default: w.spread = $urandom_range(0, 32'h0100_0000);
    endcase
    return w;
  endfunction

  task automatic test_extremes();
    send_word(mk_word(0, 0, 0, 32'h0001_0000));
    send_word(mk_word(32768, 32768, 5, 32'h0001_0000));
    send_word(mk_word(65535, 65535, -1, 32'hFFFF_FFFF));
    send_word(mk_word(65535, 65535, 0, 0));
    send_word(mk_word(32769, 32768, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_word(mk_word(32768, 32769, 32'h8000_0000, 32'hFFFF_FFFF));
    send_word(mk_word(32767, 32768, 32'h8000_0000, 32'hFFFF_FFFF));
    send_word(mk_word(32768, 32767, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_word(mk_word(9600, 32768, 0, 32'h0001_0000));
    send_word(mk_word(32768, 9600, 0, 32'h0001_0000));
  endtask

  task automatic test_store_path();
    send_word(mk_word(40000, 20000, 32'h0003_0000, 32'h0002_0000));
    send_word(mk_word(0, 0, -32'sh0003_0000, 0));
    send_word(mk_word(50000, 50000, 0, 32'hFFFF_FFFF));
    send_word(mk_word(32768, 32768, 32'h8000_0000, 32'hFFFF_FFFF));
    send_word(mk_word(1000, 64000, 0, 32'h0001_0000));
    send_word(mk_word(65535, 0, 32'h7FFF_FFFF, 32'h0001_0000));
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (30) send_word(rand_word());
    no_idle = 1'b0;
  endtask

  task automatic test_random();
    repeat (600) send_word(rand_word());
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_extremes();
    test_store_path();
    test_back_to_back();
    test_random();
    in_valid_i = 1'b0;
    while (deviate_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      hold = no_idle ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall_i = 1'b1;
        repeat (hold - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    pgd_pkg::out_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (deviate_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %h", $time, out_word_o);
      end else begin
        exp_w = deviate_q.pop_front();
        if (out_word_o.deviate !== exp_w.deviate) begin
          errors++;
          $display("%0t: deviate exp %h got %h", $time, exp_w.deviate, out_word_o.deviate);
        end
        if (out_word_o.rejected !== exp_w.rejected) begin
          errors++;
          $display("%0t: rejected exp %b got %b", $time, exp_w.rejected,
                   out_word_o.rejected);
        end
        if (out_word_o.from_store !== exp_w.from_store) begin
          errors++;
          $display("%0t: from_store exp %b got %b", $time, exp_w.from_store,
                   out_word_o.from_store);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule
